>>> rtl/sbrd_pkg.sv
// Shared types and constants of the seven-bit RLE decoder.
package sbrd_pkg;

   // Width of the per-message produced-byte total
   localparam int TOTAL_BITS = 16;
   // Width of totals and capacities during the room check
   localparam int SUM_W = ((TOTAL_BITS > 16) ? TOTAL_BITS : 16) + 1;

   // Command queue between the front and the back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Most data bytes in one dense group
   localparam int GROUP_MAX = 5;

   // End-of-message status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_RESERVED  = 3'd1,
      ST_GROUP_CUT = 3'd2,
      ST_EXT_CUT   = 3'd3,
      ST_GROUP_OVF = 3'd4,
      ST_RUN_OVF   = 3'd5
   } status_type;

   // One command: up to five data items, optionally followed by an end item
   typedef struct packed {
      logic [2:0]                num;
      logic                      run;
      logic [GROUP_MAX-1:0][7:0] data;
      logic [8:0]                count;
      logic                      done;
      status_type                status;
      logic [TOTAL_BITS-1:0]     total;
   } cmd_type;

endpackage

>>> rtl/sbrd_front.sv
// Front part: accepts encoded bytes, tracks decode state and issues commands.
module sbrd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_in_byte,
   input  logic             req_in_last,
   output logic             req_full,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data,
   input  logic             queue_full,
   output logic             cmd_push,
   output sbrd_pkg::cmd_type cmd
);
   import sbrd_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_GROUP,
      PH_EXT,
      PH_VALUE,
      PH_HALT
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [2:0]                size_ff, size_in;
   logic [2:0]                fill_ff, fill_in;
   logic [4:0]                high_ff, high_in;
   logic [GROUP_MAX-1:0][7:0] bytes_ff, bytes_in;
   logic [8:0]                len_ff, len_in;
   logic                      run_high_ff, run_high_in;
   logic [TOTAL_BITS-1:0]     total_ff, total_in;
   status_type                halt_ff, halt_in;
   logic [15:0]               capacity_ff;

   logic             accept;
   logic [8:0]       add_n;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] cap_ext;
   logic [SUM_W-1:0] mask_ext;
   logic [SUM_W-1:0] cap;
   logic             ovf;
   logic [7:0]       grp_byte;
   logic [7:0]       run_byte;
   logic [3:0]       fill_next;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // Room check: the add both tests capacity and gives the new total
   assign add_n    = (phase_ff == PH_GROUP) ? {6'd0, size_ff} : len_ff;
   assign sum      = SUM_W'(total_ff) + SUM_W'(add_n);
   assign cap_ext  = SUM_W'(capacity_ff);
   assign mask_ext = SUM_W'({TOTAL_BITS{1'b1}});
   assign cap      = (cap_ext < mask_ext) ? cap_ext : mask_ext;
   assign ovf      = (add_n != 9'd0) && (sum > cap);

   assign grp_byte  = {high_ff[fill_ff], req_in_byte[6:0]};
   assign run_byte  = {run_high_ff, req_in_byte[6:0]};
   assign fill_next = {1'b0, fill_ff} + 4'd1;

   // Next decode state and the command for this byte
   always_comb begin
      phase_in    = phase_ff;
      size_in     = size_ff;
      fill_in     = fill_ff;
      high_in     = high_ff;
      bytes_in    = bytes_ff;
      len_in      = len_ff;
      run_high_in = run_high_ff;
      total_in    = total_ff;
      halt_in     = halt_ff;
      cmd         = '0;
      cmd_push    = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (!req_in_last) begin
                  if (req_in_byte inside {[8'd0:8'd3]}) begin
                     size_in  = 3'd2;
                     high_in  = req_in_byte[4:0];
                     fill_in  = 3'd0;
                     phase_in = PH_GROUP;
                  end else if (req_in_byte inside {[8'd4:8'd11]}) begin
                     size_in  = 3'd3;
                     high_in  = 5'(req_in_byte - 8'd4);
                     fill_in  = 3'd0;
                     phase_in = PH_GROUP;
                  end else if (req_in_byte inside {[8'd12:8'd27]}) begin
                     size_in  = 3'd4;
                     high_in  = 5'(req_in_byte - 8'd12);
                     fill_in  = 3'd0;
                     phase_in = PH_GROUP;
                  end else if (req_in_byte inside {[8'd28:8'd59]}) begin
                     size_in  = 3'd5;
                     high_in  = 5'(req_in_byte - 8'd28);
                     fill_in  = 3'd0;
                     phase_in = PH_GROUP;
                  end else if (req_in_byte inside {[8'd60:8'd63]}) begin
                     halt_in  = ST_RESERVED;
                     phase_in = PH_HALT;
                  end else begin
                     run_high_in = req_in_byte[0];
                     len_in      = {2'd0, req_in_byte[7:1]} - 9'd32;
                     phase_in    = (req_in_byte[7:1] == 7'd63) ? PH_EXT : PH_VALUE;
                  end
               end
            end
            PH_GROUP: begin
               bytes_in[fill_ff] = grp_byte;
               fill_in           = fill_next[2:0];
               if (fill_next >= {1'b0, size_ff}) begin
                  if (ovf) begin
                     halt_in  = ST_GROUP_OVF;
                     phase_in = PH_HALT;
                  end else begin
                     cmd.num  = size_ff;
                     cmd.data = bytes_in;
                     total_in = sum[TOTAL_BITS-1:0];
                     phase_in = PH_HEADER;
                  end
               end else if (req_in_last) begin
                  halt_in  = ST_GROUP_CUT;
                  phase_in = PH_HALT;
               end
            end
            PH_EXT: begin
               len_in = 9'd31 + {1'b0, req_in_byte};
               if (req_in_last) begin
                  halt_in  = ST_EXT_CUT;
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (ovf) begin
                  halt_in  = ST_RUN_OVF;
                  phase_in = PH_HALT;
               end else begin
                  if (len_ff != 9'd0) begin
                     cmd.num     = 3'd1;
                     cmd.run     = 1'b1;
                     cmd.data[0] = run_byte;
                     cmd.count   = len_ff;
                  end
                  total_in = sum[TOTAL_BITS-1:0];
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               // halted: drop bytes until the last one
            end
         endcase

         // Close the message on its last byte
         if (req_in_last) begin
            cmd.done    = 1'b1;
            cmd.status  = halt_in;
            cmd.total   = total_in;
            phase_in    = PH_HEADER;
            size_in     = 3'd0;
            fill_in     = 3'd0;
            high_in     = 5'd0;
            len_in      = 9'd0;
            run_high_in = 1'b0;
            total_in    = '0;
            halt_in     = ST_OK;
         end

         cmd_push = (cmd.num != 3'd0) || cmd.done;
      end
   end

   // Hold decode state and the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         size_ff     <= 3'd0;
         fill_ff     <= 3'd0;
         high_ff     <= 5'd0;
         len_ff      <= 9'd0;
         run_high_ff <= 1'b0;
         total_ff    <= '0;
         halt_ff     <= ST_OK;
         capacity_ff <= 16'hffff;
      end else begin
         phase_ff    <= phase_in;
         size_ff     <= size_in;
         fill_ff     <= fill_in;
         high_ff     <= high_in;
         len_ff      <= len_in;
         run_high_ff <= run_high_in;
         total_ff    <= total_in;
         halt_ff     <= halt_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // Group bytes need no reset: each is written before it is read
   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

endmodule

>>> rtl/sbrd_queue.sv
// Short command queue between the front and the back.
module sbrd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  sbrd_pkg::cmd_type wr_cmd,
   input  logic              rd_en,
   output sbrd_pkg::cmd_type rd_cmd,
   output logic              full,
   output logic              empty
);
   import sbrd_pkg::*;

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full   = (count_ff == QCNT_W'(QDEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_en ? (wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = rd_en ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the written command
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en) else $error("queue written while full");
   a_no_read_when_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !rd_en) else $error("queue read while empty");
`endif

endmodule

>>> rtl/sbrd_back.sv
// Back part: expands queued commands into result items, one item per pop.
module sbrd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  sbrd_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic [8:0]        rsp_out_count,
   output logic              rsp_out_done,
   output logic [2:0]        rsp_out_status,
   output logic [15:0]       rsp_out_total
);
   import sbrd_pkg::*;

   cmd_type    cur_ff;
   logic [2:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;

   logic             taken;
   logic [2:0]       num_items;
   logic             last_item;
   logic [SUM_W-1:0] total_ext;

   assign rsp_empty = !busy_ff;
   assign taken     = busy_ff && rsp_pop;
   assign num_items = cur_ff.num + {2'd0, cur_ff.done};
   assign last_item = (3'(idx_ff + 3'd1) == num_items);
   assign q_pop     = !q_empty && (!busy_ff || (taken && last_item));
   assign total_ext = SUM_W'(cur_ff.total);

   // Select the item under the index
   always_comb begin
      rsp_out_byte   = 8'd0;
      rsp_out_count  = 9'd0;
      rsp_out_done   = 1'b0;
      rsp_out_status = ST_OK;
      rsp_out_total  = 16'd0;
      if (idx_ff < cur_ff.num) begin
         if (cur_ff.run) begin
            rsp_out_byte  = cur_ff.data[0];
            rsp_out_count = cur_ff.count;
         end else begin
            rsp_out_byte  = cur_ff.data[idx_ff];
            rsp_out_count = 9'd1;
         end
      end else begin
         rsp_out_done   = 1'b1;
         rsp_out_status = cur_ff.status;
         rsp_out_total  = total_ext[15:0];
      end
   end

   // Step through the command, load the next one when done
   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         idx_in  = 3'd0;
         busy_in = 1'b1;
      end else if (taken) begin
         if (last_item) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_cmd;
      end
   end

`ifndef SYNTHESIS
   a_end_item_no_copies: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_done) |-> (rsp_out_count == 9'd0))
      else $error("end item carries copies");
   a_data_item_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_out_done) |->
         (rsp_out_count != 9'd0 && rsp_out_status == ST_OK && rsp_out_total == 16'd0))
      else $error("malformed data item");
`endif

endmodule

>>> rtl/seven_bit_rle_decoder.sv
// Top level of the seven-bit RLE decoder: front, command queue and back.
//
// Input channel: push an encoded byte with req_in_last marking the message's
// final byte; a byte is taken on a clock edge with req_push high, req_full low.
// Result channel: while rsp_empty is low the oldest result item is on the rsp_
// ports; rsp_pop high takes it. Data items carry a byte and its copy count;
// each last byte yields an end item with status and the message's total.
// csr_wr_en/csr_wr_data write the per-message output capacity (reset 65535).
// The first result of a byte passes the front decode (combinational), then the
// command queue slot and then the back's command register.
// Throughput: the front takes one byte per cycle while req_full is low; the back
// gives one item per cycle while it has items and rsp_pop is high; a dense group of
// n bytes gives n items from n+1 input bytes. req_full rises only when the command
// queue is full, i.e. when the result side has stalled or lagged behind four commands.
// Reset (synchronous) empties the queue, drops the current command and puts
// the decoder at the start of a message with the capacity at its maximum.
module seven_bit_rle_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic [8:0]  rsp_out_count,
   output logic        rsp_out_done,
   output logic [2:0]  rsp_out_status,
   output logic [15:0] rsp_out_total,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import sbrd_pkg::*;

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    front_push;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   sbrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .req_full    (req_full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (q_full),
      .cmd_push    (front_push),
      .cmd         (front_cmd)
   );

   sbrd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (front_push),
      .wr_cmd (front_cmd),
      .rd_en  (q_pop),
      .rd_cmd (back_cmd),
      .full   (q_full),
      .empty  (q_empty)
   );

   sbrd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_cmd          (back_cmd),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_count  (rsp_out_count),
      .rsp_out_done   (rsp_out_done),
      .rsp_out_status (rsp_out_status),
      .rsp_out_total  (rsp_out_total)
   );

endmodule
